// File: rtl/arp_responder_with_cache_core_macros.svh
// Assertion macros for the ARP responder core.
`ifndef ARP_RESPONDER_WITH_CACHE_CORE_MACROS_SVH
`define ARP_RESPONDER_WITH_CACHE_CORE_MACROS_SVH
`ifndef SYNTH
// Check that cons holds in the same cycle as ante.
`define ARPC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("arpc: same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define ARPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("arpc: next-cycle check failed");
`else
`define ARPC_ASSERT_SAME(label, ante, cons)
`define ARPC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/arpc_pkg.sv
// Types and constants shared by the ARP responder core.
package arpc_pkg;

	// Protocol constants
	localparam logic [15:0] HW_TYPE_ETH  = 16'd1;
	localparam logic [15:0] OPER_REQUEST = 16'd1;

	// Result action codes
	localparam logic [2:0] ACT_BAD_HW    = 3'd0;
	localparam logic [2:0] ACT_BAD_PROTO = 3'd1;
	localparam logic [2:0] ACT_NOT_US    = 3'd2;
	localparam logic [2:0] ACT_BAD_OP    = 3'd3;
	localparam logic [2:0] ACT_REPLY     = 3'd4;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 48;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_IP        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_TYPE = 2'd2;

	localparam logic [15:0] PROTOCOL_TYPE_RESET = 16'h0800;

	typedef struct packed {
		logic [15:0] hardware_type;
		logic [15:0] proto_type;
		logic [15:0] operation;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [31:0] target_ip;
	} pkt_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [47:0] reply_target_mac;
		logic [31:0] reply_target_ip;
		logic        merged;
		logic        inserted;
		logic        table_full;
	} res_t;

	// Table commands from the sequencer
	typedef struct packed {
		logic rd;
		logic wr_mac;
		logic append;
	} tbl_ctl_t;

endpackage

// File: rtl/arp_responder_with_cache_core.sv
// ARP responder core: drop checks, sender merge, target insert and reply decision.
// Bad hardware or protocol types drop early; otherwise the table walk reads
// up to fill-count entries via the single-read IP memory and the shared compare.
// A new packet is held off (pkt_stall) until its result is registered, and a stalled
// result holds the sequencer in its done state.
// Reset: async; clears sequencer, fill count, result, own IP; protocol to 0x0800.
`include "arp_responder_with_cache_core_macros.svh"
module arp_responder_with_cache_core import arpc_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pkt_valid,
	output logic                  pkt_stall,
	input  pkt_t                  pkt,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_t                  res
);

	localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

	tbl_ctl_t         tbl_ctl;
	logic [IDX_W-1:0] tbl_addr;
	logic [31:0]      tbl_wr_ip;
	logic [47:0]      tbl_wr_mac;
	logic [CNT_W-1:0] fill;
	logic [31:0]      rd_ip;
	logic             busy;

	assign cfg_ready = 1'b1;
	assign pkt_stall = busy;

	arpc_seq #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pkt_valid (pkt_valid),
		.pkt       (pkt),
		.busy      (busy),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.tbl_ctl   (tbl_ctl),
		.tbl_addr  (tbl_addr),
		.tbl_wr_ip (tbl_wr_ip),
		.tbl_wr_mac(tbl_wr_mac),
		.fill      (fill),
		.rd_ip     (rd_ip)
	);

	arpc_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (tbl_ctl),
		.addr  (tbl_addr),
		.wr_ip (tbl_wr_ip),
		.wr_mac(tbl_wr_mac),
		.rd_ip (rd_ip),
		.fill  (fill)
	);

	// Check table bookkeeping and result consistency
	`ARPC_ASSERT_SAME(a_fill_bound, 1'b1, fill <= FULL_CNT)
	`ARPC_ASSERT_NEXT(a_append_grows, tbl_ctl.append, fill == $past(fill) + 1'b1)
	`ARPC_ASSERT_SAME(a_merge_xor_insert, res_valid, !(res.merged && res.inserted))
	`ARPC_ASSERT_SAME(a_full_means_full, res_valid && res.table_full, fill == FULL_CNT)

endmodule

// File: rtl/arpc_table.sv
// Translation table: IP and MAC memories with fill count and registered IP read.
module arpc_table import arpc_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = 16,
	localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tbl_ctl_t         ctl,
	input  logic [IDX_W-1:0] addr,
	input  logic [31:0]      wr_ip,
	input  logic [47:0]      wr_mac,
	output logic [31:0]      rd_ip,
	output logic [CNT_W-1:0] fill
);

	logic [31:0]      ip_mem  [TABLE_ENTRIES];
	logic [47:0]      mac_mem [TABLE_ENTRIES];
	logic [31:0]      rd_ip_q;
	logic [CNT_W-1:0] fill_q;
	logic [IDX_W-1:0] wa;

	// Append goes to the first free slot, merge to the searched slot
	assign wa = ctl.append ? fill_q[IDX_W-1:0] : addr;

	// Write IP on append only, MAC on append or merge
	always_ff @(posedge clk) begin
		if (ctl.append) begin
			ip_mem[wa] <= wr_ip;
		end
		if (ctl.append || ctl.wr_mac) begin
			mac_mem[wa] <= wr_mac;
		end
	end

	// Read IP for the compare
	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_ip_q <= ip_mem[addr];
		end
	end

	// Count valid entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctl.append) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	assign rd_ip = rd_ip_q;
	assign fill  = fill_q;

endmodule

// File: rtl/arpc_seq.sv
// Sequencer with one shared equality compare, config registers and result register.
module arpc_seq import arpc_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = 16,
	localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pkt_valid,
	input  pkt_t                  pkt,
	output logic                  busy,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_t                  res,
	output tbl_ctl_t              tbl_ctl,
	output logic [IDX_W-1:0]      tbl_addr,
	output logic [31:0]           tbl_wr_ip,
	output logic [47:0]           tbl_wr_mac,
	input  logic [CNT_W-1:0]      fill,
	input  logic [31:0]           rd_ip
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HW,
		S_PT,
		S_TIP,
		S_RD,
		S_CMP,
		S_UPD,
		S_DONE
	} state_t;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

	state_t           state_q;
	pkt_t             pkt_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] k_nxt;
	logic             for_us_q;
	logic             merged_q;
	logic             inserted_q;
	logic             full_q;
	logic             reply_q;
	logic [2:0]       act_q;
	logic [31:0]      own_ip_q;
	logic [15:0]      proto_q;
	res_t             res_q;
	logic             res_valid_q;
	logic [31:0]      cmp_a;
	logic [31:0]      cmp_b;
	logic             cmp_eq;
	logic             need_ins;

	// Write config registers; own MAC has no consumer inside this block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q <= '0;
			proto_q  <= PROTOCOL_TYPE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OWN_MAC: begin
				end
				REG_OWN_IP: begin
					own_ip_q <= cfg_data[31:0];
				end
				REG_PROTOCOL_TYPE: begin
					proto_q <= cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Capture the word on accept
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && pkt_valid) begin
			pkt_q <= pkt;
		end
	end

	// Steer operands into the shared compare
	always_comb begin
		case (state_q)
			S_HW: begin
				cmp_a = {16'b0, pkt_q.hardware_type};
				cmp_b = {16'b0, HW_TYPE_ETH};
			end
			S_PT: begin
				cmp_a = {16'b0, pkt_q.proto_type};
				cmp_b = {16'b0, proto_q};
			end
			S_TIP: begin
				cmp_a = pkt_q.target_ip;
				cmp_b = own_ip_q;
			end
			S_CMP: begin
				cmp_a = rd_ip;
				cmp_b = pkt_q.sender_ip;
			end
			S_UPD: begin
				cmp_a = {16'b0, pkt_q.operation};
				cmp_b = {16'b0, OPER_REQUEST};
			end
			default: begin
				cmp_a = '0;
				cmp_b = '0;
			end
		endcase
	end

	assign cmp_eq   = (cmp_a == cmp_b);
	assign k_nxt    = k_q + 1'b1;
	assign need_ins = for_us_q && !merged_q;

	// Drive table commands and write data from the held word
	assign tbl_ctl.rd     = (state_q == S_RD);
	assign tbl_ctl.wr_mac = (state_q == S_CMP) && cmp_eq;
	assign tbl_ctl.append = (state_q == S_UPD) && need_ins && (fill != FULL_CNT);
	assign tbl_addr       = k_q[IDX_W-1:0];
	assign tbl_wr_ip      = pkt_q.sender_ip;
	assign tbl_wr_mac     = pkt_q.sender_mac;

	// Advance the sequencer and hold the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			for_us_q    <= 1'b0;
			merged_q    <= 1'b0;
			inserted_q  <= 1'b0;
			full_q      <= 1'b0;
			reply_q     <= 1'b0;
			act_q       <= ACT_BAD_HW;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && state_q != S_DONE) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pkt_valid) begin
						for_us_q   <= 1'b0;
						merged_q   <= 1'b0;
						inserted_q <= 1'b0;
						full_q     <= 1'b0;
						reply_q    <= 1'b0;
						state_q    <= S_HW;
					end
				end
				S_HW: begin
					if (!cmp_eq) begin
						act_q   <= ACT_BAD_HW;
						state_q <= S_DONE;
					end else begin
						state_q <= S_PT;
					end
				end
				S_PT: begin
					if (!cmp_eq) begin
						act_q   <= ACT_BAD_PROTO;
						state_q <= S_DONE;
					end else begin
						state_q <= S_TIP;
					end
				end
				S_TIP: begin
					for_us_q <= cmp_eq;
					k_q      <= '0;
					state_q  <= (fill == '0) ? S_UPD : S_RD;
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (cmp_eq) begin
						merged_q <= 1'b1;
						state_q  <= S_UPD;
					end else begin
						k_q     <= k_nxt;
						state_q <= (k_nxt == fill) ? S_UPD : S_RD;
					end
				end
				S_UPD: begin
					if (need_ins) begin
						if (fill != FULL_CNT) begin
							inserted_q <= 1'b1;
						end else begin
							full_q <= 1'b1;
						end
					end
					if (!for_us_q) begin
						act_q <= ACT_NOT_US;
					end else if (cmp_eq) begin
						act_q   <= ACT_REPLY;
						reply_q <= 1'b1;
					end else begin
						act_q <= ACT_BAD_OP;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || !res_stall) begin
						res_q.action           <= act_q;
						res_q.reply_target_mac <= reply_q ? pkt_q.sender_mac : 48'b0;
						res_q.reply_target_ip  <= reply_q ? pkt_q.sender_ip : 32'b0;
						res_q.merged           <= merged_q;
						res_q.inserted         <= inserted_q;
						res_q.table_full       <= full_q;
						res_valid_q            <= 1'b1;
						state_q                <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule
